// ===== hdl/ketr_pkg.sv =====
// shared constants and types for the key edge and typematic repeat block
`timescale 1ns / 1ps

package ketr_pkg;

  localparam int unsigned NUM_KEYS  = 64;
  localparam int unsigned KEY_W     = 6;
  localparam int unsigned ADDR_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CNT_W     = 13;

  localparam logic [CFG_W-1:0] DELAY_RESET  = CFG_W'(30);
  localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(5);

  typedef enum logic [0:0] {
    CFG_DELAY  = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    FUNC_SOFT_ON = 1'b0,
    FUNC_FRAME   = 1'b1
  } func_e;

  typedef struct packed {
    logic                    level;
    logic                    latch;
    logic                    armed;
    logic signed [CNT_W-1:0] count;
  } key_state_t;

  localparam int unsigned STATE_W = $bits(key_state_t);

endpackage

// ===== hdl/ketr_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ketr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/key_edge_and_typematic_repeat.sv =====
// top level of the per-key press, release, hold and auto-repeat tracker
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   func_i selects a soft key-on (latch a key-on for key_index_i) or a
//   frame update of key_index_i with its sampled level raw_down_i.
//   Each frame item gives one result on the output channel
//   (out_valid_o / out_stall_i): held, press edge, release edge and repeat.
//   A soft key-on gives no result and only acts at that key's next frame.
//   Per-key state sits in one ram; an item reads its entry on transfer and
//   writes it back as it leaves stage 1, with the last write forwarded so
//   that the same key can follow in the next cycle.
//   Results are registered behind stage 1. Throughput, unless the output
//   stalls: one item per cycle, set by the single ram read-modify-write.
//   Reset clears a per-key valid flag, so every key reads as all zero; the
//   block takes items from the first cycle after reset, there is no clear
//   pass. Repeat delay resets to 30 and period to 5.
//   A stalled output holds its result and the stage before it; the input
//   then stalls once that stage is occupied.
//   Configuration is to be written only while the block is idle; the block
//   itself does not enforce this.

module key_edge_and_typematic_repeat (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [ketr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [ketr_pkg::KEY_W-1:0] key_index_i,
  input  logic                      raw_down_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      key_held_o,
  output logic                      key_pressed_o,
  output logic                      key_released_o,
  output logic                      repeat_fire_o
);

  import ketr_pkg::*;

  logic [CFG_W-1:0] delay_q, period_q;

  logic               s1_valid_q;
  logic               s1_func_q;
  logic [KEY_W-1:0]   s1_key_q;
  logic               s1_raw_q;
  logic               s1_ent_valid_q;

  logic [NUM_KEYS-1:0] ent_valid_q;

  logic               lw_valid_q;
  logic [ADDR_W-1:0]  lw_addr_q;
  key_state_t         lw_data_q;

  logic               out_valid_q;
  logic               held_q, pressed_q, released_q, fire_q;

  logic               in_xfer, can_go, s1_go, s1_in_range, mem_we;
  logic [ADDR_W-1:0]  in_addr, s1_addr;
  logic [STATE_W-1:0] ram_rdata;
  key_state_t         cur, nxt;
  logic               held_d, pressed_d, released_d, fire_d;
  logic signed [CNT_W:0] cnt_ext, delay_ext, period_ext;
  logic signed [CNT_W:0] cnt_dec;

  assign can_go     = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~can_go;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign s1_go      = s1_valid_q & can_go;

  assign in_addr     = key_index_i[ADDR_W-1:0];
  assign s1_addr     = s1_key_q[ADDR_W-1:0];
  assign s1_in_range = ({1'b0, s1_key_q} < (KEY_W+1)'(NUM_KEYS));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DELAY_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY:  delay_q  <= cfg_wdata_i;
        CFG_PERIOD: period_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  ketr_ram #(
    .Width(STATE_W),
    .Depth(NUM_KEYS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(s1_addr),
    .wdata_i(nxt),
    .re_i   (in_xfer),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  // entry as seen by the item in stage 1, with forwarding of the last write
  always_comb begin
    if (lw_valid_q && lw_addr_q == s1_addr) begin
      cur = lw_data_q;
    end else if (s1_ent_valid_q) begin
      cur = key_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  assign cnt_ext    = {cur.count[CNT_W-1], cur.count};
  assign delay_ext  = {2'b00, delay_q};
  assign period_ext = {2'b00, period_q};
  assign cnt_dec    = cnt_ext - period_ext;

  always_comb begin
    nxt        = cur;
    held_d     = 1'b0;
    pressed_d  = 1'b0;
    released_d = 1'b0;
    fire_d     = 1'b0;
    unique case (func_e'(s1_func_q))
      FUNC_SOFT_ON: begin
        nxt.latch = 1'b1;
      end
      FUNC_FRAME: begin
        nxt.level  = s1_raw_q | cur.latch;
        nxt.latch  = 1'b0;
        held_d     = nxt.level & cur.level;
        pressed_d  = nxt.level & ~cur.level;
        released_d = ~nxt.level & cur.level;
        if (pressed_d) begin
          nxt.armed = 1'b1;
          nxt.count = '0;
          fire_d    = 1'b1;
        end else if (cur.armed && held_d) begin
          if (cnt_ext >= delay_ext) begin
            nxt.count = cnt_dec[CNT_W-1:0];
            fire_d    = 1'b1;
          end else begin
            nxt.count = cur.count + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    if (!s1_in_range) begin
      held_d     = 1'b0;
      pressed_d  = 1'b0;
      released_d = 1'b0;
      fire_d     = 1'b0;
    end
  end

  assign mem_we = s1_go & s1_in_range;

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q      <= func_i;
      s1_key_q       <= key_index_i;
      s1_raw_q       <= raw_down_i;
      s1_ent_valid_q <= ent_valid_q[in_addr];
    end
  end

  // per-key written flags and last write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      lw_valid_q  <= 1'b0;
    end else if (mem_we) begin
      ent_valid_q[s1_addr] <= 1'b1;
      lw_valid_q           <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lw_addr_q <= s1_addr;
      lw_data_q <= nxt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_go) begin
      out_valid_q <= s1_valid_q & (s1_func_q == FUNC_FRAME);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      held_q     <= held_d;
      pressed_q  <= pressed_d;
      released_q <= released_d;
      fire_q     <= fire_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_held_o     = held_q;
  assign key_pressed_o  = pressed_q;
  assign key_released_o = released_q;
  assign repeat_fire_o  = fire_q;

endmodule

// ===== sim/typematic_result_check.sv =====
// checker: predicts each frame result from the observed transfers and compares
`timescale 1ns / 1ps

module typematic_result_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [ketr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      func_i,
  input  logic [ketr_pkg::KEY_W-1:0] key_index_i,
  input  logic                      raw_down_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      key_held_i,
  input  logic                      key_pressed_i,
  input  logic                      key_released_i,
  input  logic                      repeat_fire_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  import ketr_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             held;
    logic             pressed;
    logic             released;
    logic             fire;
  } key_result_t;

  logic                    level_now  [NUM_KEYS];
  logic                    level_prev [NUM_KEYS];
  logic                    soft_on    [NUM_KEYS];
  logic                    armed      [NUM_KEYS];
  logic signed [CNT_W-1:0] rep_count  [NUM_KEYS];
  logic [CFG_W-1:0]        delay_cfg;
  logic [CFG_W-1:0]        period_cfg;
  key_result_t             frame_results_q [$];
  key_result_t             want;

  function automatic key_result_t typematic_step(logic [KEY_W-1:0] k, logic raw);
    key_result_t r;
    logic        now_l;
    logic        prev_l;
    int          c;
    r = '0;
    r.key = k;
    if (int'(k) >= NUM_KEYS) begin
      return r;
    end
    prev_l = level_now[k];
    now_l = raw | soft_on[k];
    level_prev[k] = prev_l;
    level_now[k] = now_l;
    soft_on[k] = 1'b0;
    r.held = now_l & prev_l;
    r.pressed = now_l & ~prev_l;
    r.released = ~now_l & prev_l;
    if (r.pressed) begin
      armed[k] = 1'b1;
      rep_count[k] = '0;
      r.fire = 1'b1;
    end else if (armed[k] && r.held) begin
      c = int'(rep_count[k]);
      if (c >= int'(delay_cfg)) begin
        c = c - int'(period_cfg);
        r.fire = 1'b1;
      end else begin
        c = c + 1;
      end
      rep_count[k] = CNT_W'(c);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        level_now[i] = 1'b0;
        level_prev[i] = 1'b0;
        soft_on[i] = 1'b0;
        armed[i] = 1'b0;
        rep_count[i] = '0;
      end
      delay_cfg = DELAY_RESET;
      period_cfg = PERIOD_RESET;
      frame_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_DELAY) begin
          delay_cfg = cfg_wdata_i;
        end else begin
          period_cfg = cfg_wdata_i;
        end
      end
      // result transfer
      if (out_valid_i && !out_stall_i) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: result with none expected (held %0b pressed %0b released %0b fire %0b)",
                   $time, key_held_i, key_pressed_i, key_released_i, repeat_fire_i);
          fail_count_o++;
        end else begin
          want = frame_results_q.pop_front();
          if (key_held_i !== want.held) begin
            $display("%0t: key %0d held expected %0b got %0b",
                     $time, want.key, want.held, key_held_i);
            fail_count_o++;
          end
          if (key_pressed_i !== want.pressed) begin
            $display("%0t: key %0d pressed expected %0b got %0b",
                     $time, want.key, want.pressed, key_pressed_i);
            fail_count_o++;
          end
          if (key_released_i !== want.released) begin
            $display("%0t: key %0d released expected %0b got %0b",
                     $time, want.key, want.released, key_released_i);
            fail_count_o++;
          end
          if (repeat_fire_i !== want.fire) begin
            $display("%0t: key %0d repeat expected %0b got %0b",
                     $time, want.key, want.fire, repeat_fire_i);
            fail_count_o++;
          end
        end
      end
      // item transfer
      if (in_valid_i && !in_stall_i) begin
        if (func_e'(func_i) == FUNC_SOFT_ON) begin
          if (int'(key_index_i) < NUM_KEYS) begin
            soft_on[key_index_i] = 1'b1;
          end
        end else begin
          frame_results_q.push_back(typematic_step(key_index_i, raw_down_i));
        end
      end
      pending_o = frame_results_q.size();
    end
  end

endmodule

// ===== sim/key_edge_and_typematic_repeat_tb.sv =====
// testbench top: stimulus, handshake idling and verdict for the key repeat tracker
`timescale 1ns / 1ps

module key_edge_and_typematic_repeat_tb;
  import ketr_pkg::*;

  localparam int HOLDOFF_CYCLES = 64;
  localparam int SETTING_N      = 9;
  localparam int ITEMS_PER_SET  = 82;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             func_i;
  logic [KEY_W-1:0] key_index_i;
  logic             raw_down_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             key_held_o;
  logic             key_pressed_o;
  logic             key_released_o;
  logic             repeat_fire_o;

  int   fail_count;
  int   pending;
  int   send_gap_pct;
  int   recv_gap_pct;
  logic holdoff_req;
  logic holdoff_done;

  int delay_set  [SETTING_N] = '{30, 0, 1, 4, 3, 4095, 4095, 0, 10};
  int period_set [SETTING_N] = '{5, 0, 1, 2, 7, 4095, 0, 4095, 3};

  key_edge_and_typematic_repeat dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .key_index_i    (key_index_i),
    .raw_down_i     (raw_down_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_held_o     (key_held_o),
    .key_pressed_o  (key_pressed_o),
    .key_released_o (key_released_o),
    .repeat_fire_o  (repeat_fire_o)
  );

  typematic_result_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .key_index_i    (key_index_i),
    .raw_down_i     (raw_down_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_held_i     (key_held_o),
    .key_pressed_i  (key_pressed_o),
    .key_released_i (key_released_o),
    .repeat_fire_i  (repeat_fire_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_stall_i  = 1'b0;
    holdoff_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req && !holdoff_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        holdoff_done = 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_gap_pct);
      end
    end
  end

  task automatic offer_item(input func_e f, input logic [KEY_W-1:0] k, input logic raw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    key_index_i <= k;
    raw_down_i  <= raw;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    // soft key-on transfers leave nothing to wait for, so allow for the pipeline
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input int delay_v, input int period_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DELAY;
    cfg_wdata_i <= CFG_W'(delay_v);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PERIOD;
    cfg_wdata_i <= CFG_W'(period_v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic key_traffic(input int n_items, input int delay_v);
    logic [KEY_W-1:0] pool [4];
    logic [KEY_W-1:0] k;
    int               sent;
    int               run_len;
    for (int i = 0; i < 4; i++) pool[i] = KEY_W'($urandom_range(NUM_KEYS - 1));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 20) begin
        offer_item(func_e'($urandom_range(1)), KEY_W'($urandom_range(NUM_KEYS - 1)),
                   1'($urandom_range(1)));
        sent++;
      end else begin
        // hold one key for a random run, which may reach the repeat, then let it go
        k = pool[$urandom_range(3)];
        run_len = $urandom_range(1, (delay_v < 30) ? delay_v + 12 : 42);
        for (int j = 0; j < run_len; j++) begin
          if ($urandom_range(9) == 0) begin
            offer_item(FUNC_FRAME, pool[$urandom_range(3)], 1'($urandom_range(1)));
            sent++;
          end
          if ($urandom_range(7) == 0) begin
            offer_item(FUNC_SOFT_ON, k, 1'($urandom_range(1)));
            offer_item(FUNC_FRAME, k, 1'b0);
            sent += 2;
          end else begin
            offer_item(FUNC_FRAME, k, 1'b1);
            sent++;
          end
        end
        offer_item(FUNC_FRAME, k, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_DELAY;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_FRAME;
    key_index_i  = '0;
    raw_down_i   = 1'b0;
    holdoff_req  = 1'b0;
    send_gap_pct = 8;
    recv_gap_pct = 51;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: latch presses, releases without disarm, extreme keys
    offer_item(FUNC_SOFT_ON, 6'd0, 1'b0);
    offer_item(FUNC_FRAME, 6'd0, 1'b0);
    offer_item(FUNC_FRAME, 6'd0, 1'b0);
    offer_item(FUNC_FRAME, 6'd0, 1'b1);
    offer_item(FUNC_FRAME, 6'd0, 1'b1);
    offer_item(FUNC_FRAME, 6'd0, 1'b0);
    offer_item(FUNC_FRAME, 6'd63, 1'b1);
    offer_item(FUNC_FRAME, 6'd63, 1'b1);
    offer_item(FUNC_SOFT_ON, 6'd63, 1'b1);
    offer_item(FUNC_FRAME, 6'd63, 1'b0);
    offer_item(FUNC_FRAME, 6'd63, 1'b0);
    offer_item(FUNC_FRAME, 6'd63, 1'b0);
    offer_item(FUNC_SOFT_ON, 6'd42, 1'b0);
    offer_item(FUNC_SOFT_ON, 6'd42, 1'b0);
    offer_item(FUNC_FRAME, 6'd42, 1'b1);
    offer_item(FUNC_FRAME, 6'd42, 1'b0);
    offer_item(FUNC_FRAME, 6'd21, 1'b0);
    offer_item(FUNC_SOFT_ON, 6'd21, 1'b0);
    offer_item(FUNC_FRAME, 6'd21, 1'b1);
    offer_item(FUNC_FRAME, 6'd21, 1'b1);
    offer_item(FUNC_FRAME, 6'd21, 1'b0);

    for (int p = 0; p < SETTING_N; p++) begin
      drain_results();
      write_setting(delay_set[p], period_set[p]);
      case (p / 3)
        0: begin
          send_gap_pct = 8;
          recv_gap_pct = 51;
        end
        1: begin
          send_gap_pct = 51;
          recv_gap_pct = 8;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      if (p == 6) holdoff_req = 1'b1;
      key_traffic(ITEMS_PER_SET, delay_set[p]);
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
